FILE: rtl/pwlc_pkg.sv
// Shared types and constants for the piecewise linear colormap.
`timescale 1ns / 1ps
package pwlc_pkg;
   localparam int MAX_POINTS_DEF = 6;
   localparam int INDEX_BITS_DEF = 12;

   localparam int CSR_DATA_W  = 36;
   localparam int CSR_INDEX_W = 4;
   localparam int POS_HI      = 35;
   localparam int POS_LO      = 24;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int SPAN_W      = 13;
   localparam int NUM_W       = CHAN_W + SPAN_W + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_SIZE  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_BASE  = 4'd2;

   localparam logic [12:0] TABLE_SIZE_RESET  = 13'd256;
   localparam logic [2:0]  POINT_COUNT_RESET = 3'd2;
   localparam logic [CSR_DATA_W-1:0] POINT_WHITE_RESET = 36'h0FFFFFFFF;
   localparam logic [CSR_DATA_W-1:0] POINT_BLACK_RESET = 36'h0;

   // one classified item: endpoint colors and the three interpolation spans
   typedef struct packed {
      logic [COLOR_W-1:0] c1;
      logic [COLOR_W-1:0] c2;
      logic [SPAN_W-1:0]  a;
      logic [SPAN_W-1:0]  b;
      logic [SPAN_W-1:0]  d;
      logic               clamped;
   } item_type;

   // handshake between two stages
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;
endpackage

FILE: rtl/pwlc_front.sv
// Front end: configuration registers, index clamp and segment selection.
`timescale 1ns / 1ps
module pwlc_front #(
   parameter int MAX_POINTS = pwlc_pkg::MAX_POINTS_DEF,
   parameter int INDEX_BITS = pwlc_pkg::INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pwlc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pwlc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [13:0]                   req_pixel_index,
   output pwlc_pkg::hs_type                     q_hs_out,
   input  logic                                 q_ready,
   output pwlc_pkg::item_type                   q_item
);
   localparam int SW = pwlc_pkg::SPAN_W;

   logic [12:0]                        table_size_ff;
   logic [2:0]                         point_count_ff;
   logic [pwlc_pkg::CSR_DATA_W-1:0]    point_ff [MAX_POINTS];
   logic                               f_valid_ff, f_valid_in;
   pwlc_pkg::item_type                 f_item_ff, f_item_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff  <= pwlc_pkg::TABLE_SIZE_RESET;
         point_count_ff <= pwlc_pkg::POINT_COUNT_RESET;
         for (int k = 0; k < MAX_POINTS; k++) begin
            point_ff[k] <= (k == 1) ? pwlc_pkg::POINT_WHITE_RESET
                                    : pwlc_pkg::POINT_BLACK_RESET;
         end
      end else if (csr_write_enable) begin
         if (csr_index == pwlc_pkg::CSR_TABLE_SIZE) begin
            table_size_ff <= csr_write_data[12:0];
         end else if (csr_index == pwlc_pkg::CSR_POINT_COUNT) begin
            point_count_ff <= csr_write_data[2:0];
         end else begin
            for (int k = 0; k < MAX_POINTS; k++) begin
               if (csr_index == pwlc_pkg::CSR_POINT_BASE + pwlc_pkg::CSR_INDEX_W'(k)) begin
                  point_ff[k] <= csr_write_data;
               end
            end
         end
      end
   end

   always_comb begin
      logic [SW-1:0]      size, top, i, p, runmax, first, p1, p2;
      logic [SW-1:0]      pos_ext;
      logic [2:0]         cnt;
      logic               have, found;
      logic [23:0]        prev_c, c1, c2, col;
      size = (table_size_ff == 13'd0) ? SW'(1) : table_size_ff;
      if (size > SW'(1 << INDEX_BITS)) size = SW'(1 << INDEX_BITS);
      top = size - SW'(1);
      f_item_in.clamped = 1'b0;
      if (req_pixel_index < 0) begin
         i = '0;
         f_item_in.clamped = 1'b1;
      end else if (SW'(unsigned'(req_pixel_index[12:0])) > top) begin
         i = top;
         f_item_in.clamped = 1'b1;
      end else begin
         i = SW'(unsigned'(req_pixel_index[12:0]));
      end
      cnt = (point_count_ff > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : point_count_ff;
      have = 1'b0; found = 1'b0;
      runmax = '0; first = '0; p1 = '0; p2 = '0;
      prev_c = '0; c1 = '0; c2 = '0;
      // kept points rise strictly, so the last kept one is the running max
      for (int k = 0; k < MAX_POINTS; k++) begin
         pos_ext = SW'(point_ff[k][pwlc_pkg::POS_HI:pwlc_pkg::POS_LO]);
         col = point_ff[k][23:0];
         p = (pos_ext > top) ? top : pos_ext;
         if (3'(k) < cnt && (!have || p > runmax)) begin
            if (have && !found && i >= runmax && i < p) begin
               found = 1'b1;
               p1 = runmax; p2 = p; c1 = prev_c; c2 = col;
            end
            if (!have) first = p;
            runmax = p;
            prev_c = col;
            have = 1'b1;
         end
      end
      f_item_in.c1 = '0; f_item_in.c2 = '0;
      f_item_in.a = SW'(1); f_item_in.b = '0; f_item_in.d = SW'(1);
      if (have && i >= first && i <= runmax) begin
         if (i == runmax || !found) begin
            f_item_in.c1 = prev_c;
            f_item_in.c2 = prev_c;
         end else begin
            f_item_in.c1 = c1;
            f_item_in.c2 = c2;
            f_item_in.a = p2 - i;
            f_item_in.b = i - p1;
            f_item_in.d = p2 - p1;
         end
      end
   end

   assign req_ready  = !f_valid_ff || q_ready;
   assign f_valid_in = req_ready ? req_valid : f_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         f_item_ff <= f_item_in;
      end
   end

   assign q_hs_out.valid = f_valid_ff;
   assign q_hs_out.ready = q_ready;
   assign q_item         = f_item_ff;
endmodule

FILE: rtl/pwlc_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module pwlc_queue (
   input  logic               clock,
   input  logic               reset,
   input  pwlc_pkg::hs_type   in_hs,
   output logic               in_ready,
   input  pwlc_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output pwlc_pkg::item_type out_item
);
   localparam int DEPTH = pwlc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   pwlc_pkg::item_type entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]        count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff < (PW+1)'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_hs.valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (PW+1)'(1);
      if (pop && !push) count_in = count_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_item;
   end
endmodule

FILE: rtl/pwlc_back.sv
// Back end: weighted sums, then an 8-stage restoring divide per channel.
`timescale 1ns / 1ps
module pwlc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  pwlc_pkg::item_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_clamped
);
   localparam int NW = pwlc_pkg::NUM_W;
   localparam int SW = pwlc_pkg::SPAN_W;
   localparam int CW = pwlc_pkg::CHAN_W;
   localparam int ST = CW;

   logic          advance;
   logic          m_valid_ff;
   logic [NW-1:0] m_num_ff [3];
   logic [SW-1:0] m_d_ff;
   logic          m_clamped_ff;

   logic          s_valid_ff [ST];
   logic [NW-1:0] s_rem_ff [ST][3], s_rem_in [ST][3];
   logic [CW-1:0] s_q_ff [ST][3], s_q_in [ST][3];
   logic [SW-1:0] s_d_ff [ST];
   logic          s_clamped_ff [ST];

   // whole pipeline moves together; output register frees on transfer
   assign advance = !s_valid_ff[ST-1] || rsp_ready;
   assign q_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         for (int j = 0; j < ST; j++) s_valid_ff[j] <= 1'b0;
      end else if (advance) begin
         m_valid_ff    <= q_valid;
         s_valid_ff[0] <= m_valid_ff;
         for (int j = 1; j < ST; j++) s_valid_ff[j] <= s_valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 3; ch++) begin
            m_num_ff[ch] <= NW'(q_item.c1[ch*CW +: CW]) * NW'(q_item.a)
                          + NW'(q_item.c2[ch*CW +: CW]) * NW'(q_item.b);
         end
         m_d_ff       <= q_item.d;
         m_clamped_ff <= q_item.clamped;
      end
   end

   always_comb begin
      logic [NW-1:0] rem, trial;
      logic [CW-1:0] q;
      for (int j = 0; j < ST; j++) begin
         for (int ch = 0; ch < 3; ch++) begin
            rem   = (j == 0) ? m_num_ff[ch] : s_rem_ff[(j == 0) ? 0 : j-1][ch];
            q     = (j == 0) ? '0 : s_q_ff[(j == 0) ? 0 : j-1][ch];
            trial = NW'((j == 0) ? m_d_ff : s_d_ff[(j == 0) ? 0 : j-1]) << (CW-1-j);
            if (rem >= trial) begin
               rem = rem - trial;
               q[CW-1-j] = 1'b1;
            end
            s_rem_in[j][ch] = rem;
            s_q_in[j][ch]   = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < ST; j++) begin
            s_rem_ff[j] <= s_rem_in[j];
            s_q_ff[j]   <= s_q_in[j];
         end
         s_d_ff[0]       <= m_d_ff;
         s_clamped_ff[0] <= m_clamped_ff;
         for (int j = 1; j < ST; j++) begin
            s_d_ff[j]       <= s_d_ff[j-1];
            s_clamped_ff[j] <= s_clamped_ff[j-1];
         end
      end
   end

   assign rsp_valid   = s_valid_ff[ST-1];
   assign rsp_red     = s_q_ff[ST-1][2];
   assign rsp_green   = s_q_ff[ST-1][1];
   assign rsp_blue    = s_q_ff[ST-1][0];
   assign rsp_clamped = s_clamped_ff[ST-1];
endmodule

FILE: rtl/piecewise_linear_colormap.sv
// Top level of the piecewise linear colormap.
// Usage:
//   req_*: one signed pixel index per transfer (valid/ready).
//   rsp_*: one RGB color plus a clamped flag per transfer, in order.
//   csr_*: write-only register port; write only while the block is idle.
// Path: the front register loads on the request transfer, then the queue,
//   the weighted-sum stage and eight divide stages lead to response valid.
// Throughput: one item per cycle unless the receiver stalls; the divide
//   pipeline resolves one quotient bit per stage and never loops back on itself.
// Reset (synchronous) restores the register defaults (256 entries, black to
//   white over positions 0..255) and empties the pipeline and queue.
// When the receiver stalls, the back pipeline holds; the queue and front
//   register absorb up to three more items before req_ready drops.
`timescale 1ns / 1ps
module piecewise_linear_colormap #(
   parameter int MAX_POINTS = pwlc_pkg::MAX_POINTS_DEF,
   parameter int INDEX_BITS = pwlc_pkg::INDEX_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pwlc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwlc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [13:0]               req_pixel_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   output logic                             rsp_clamped
);
   pwlc_pkg::hs_type   front_hs;
   pwlc_pkg::item_type front_item, back_item;
   logic               q_in_ready, q_out_valid, q_out_ready;

   pwlc_front #(.MAX_POINTS(MAX_POINTS), .INDEX_BITS(INDEX_BITS)) u_front (
      .clock, .reset,
      .csr_write_enable, .csr_index, .csr_write_data,
      .req_valid, .req_ready, .req_pixel_index,
      .q_hs_out(front_hs), .q_ready(q_in_ready), .q_item(front_item)
   );

   pwlc_queue u_queue (
      .clock, .reset,
      .in_hs(front_hs), .in_ready(q_in_ready), .in_item(front_item),
      .out_valid(q_out_valid), .out_ready(q_out_ready), .out_item(back_item)
   );

   pwlc_back u_back (
      .clock, .reset,
      .q_valid(q_out_valid), .q_ready(q_out_ready), .q_item(back_item),
      .rsp_valid, .rsp_ready, .rsp_red, .rsp_green, .rsp_blue, .rsp_clamped
   );
endmodule

FILE: rtl/pwlc_checker.sv
// Port-level assertions for the colormap, bound to the top level.
`timescale 1ns / 1ps
module pwlc_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_clamped
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_clamped))
      else $error("stalled response changed");
endmodule

bind piecewise_linear_colormap pwlc_port_checker u_pwlc_port_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_red, .rsp_green, .rsp_blue, .rsp_clamped
);

FILE: verif/pwlc_checker.sv
// Checker for the piecewise linear colormap: predicts colors and compares responses.
`timescale 1ns / 1ps
module pwlc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pwlc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwlc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [13:0]               req_pixel_index,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [7:0]                       rsp_red,
   input  logic [7:0]                       rsp_green,
   input  logic [7:0]                       rsp_blue,
   input  logic                             rsp_clamped,
   output int                               fail_count,
   output int                               pending
);
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       clamped;
   } color_type;

   logic [12:0]                     size_reg;
   logic [2:0]                      count_reg;
   logic [pwlc_pkg::CSR_DATA_W-1:0] point_reg [6];
   color_type                       color_q [$];

   function automatic logic [7:0] blend(int c1, int c2, int p1, int p2, int i);
      return 8'((c1 * (p2 - i) + c2 * (i - p1)) / (p2 - p1));
   endfunction

   function automatic color_type map_index(logic signed [13:0] pix);
      color_type r;
      int sz, top, i, kept, cnt, p, s;
      int pos [6];
      logic [23:0] col [6];
      logic [23:0] a, b;
      r = '0;
      sz = size_reg;
      if (sz == 0) sz = 1;
      if (sz > 4096) sz = 4096;
      top = sz - 1;
      i = pix;
      if (i < 0) begin
         i = 0;
         r.clamped = 1'b1;
      end else if (i > top) begin
         i = top;
         r.clamped = 1'b1;
      end
      kept = 0;
      cnt = (count_reg > 6) ? 6 : count_reg;
      for (int k = 0; k < cnt; k++) begin
         p = point_reg[k][pwlc_pkg::POS_HI:pwlc_pkg::POS_LO];
         if (p > top) p = top;
         if (kept == 0 || p > pos[kept-1]) begin
            pos[kept] = p;
            col[kept] = point_reg[k][23:0];
            kept++;
         end
      end
      if (kept > 0 && i >= pos[0] && i <= pos[kept-1]) begin
         if (i == pos[kept-1]) begin
            {r.red, r.green, r.blue} = col[kept-1];
         end else begin
            s = 0;
            while (s + 1 < kept && !(i >= pos[s] && i < pos[s+1])) s++;
            a = col[s];
            b = col[s+1];
            r.red   = blend(a[23:16], b[23:16], pos[s], pos[s+1], i);
            r.green = blend(a[15:8], b[15:8], pos[s], pos[s+1], i);
            r.blue  = blend(a[7:0], b[7:0], pos[s], pos[s+1], i);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      color_type exp_c;
      if (reset) begin
         size_reg  <= pwlc_pkg::TABLE_SIZE_RESET;
         count_reg <= pwlc_pkg::POINT_COUNT_RESET;
         for (int k = 0; k < 6; k++) point_reg[k] <= pwlc_pkg::POINT_BLACK_RESET;
         point_reg[1] <= pwlc_pkg::POINT_WHITE_RESET;
         color_q.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == pwlc_pkg::CSR_TABLE_SIZE) size_reg <= csr_write_data[12:0];
            else if (csr_index == pwlc_pkg::CSR_POINT_COUNT)
               count_reg <= csr_write_data[2:0];
            else if (csr_index < pwlc_pkg::CSR_POINT_BASE + 6)
               point_reg[csr_index - pwlc_pkg::CSR_POINT_BASE] <= csr_write_data;
         end
         if (req_valid && req_ready) color_q.push_back(map_index(req_pixel_index));
         if (rsp_valid && rsp_ready) begin
            if (color_q.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_c = color_q.pop_front();
               if (rsp_red !== exp_c.red || rsp_green !== exp_c.green
                   || rsp_blue !== exp_c.blue || rsp_clamped !== exp_c.clamped)
                  fail_count <= fail_count + 1;
               if (rsp_red !== exp_c.red)
                  $error("red: expected %0d, got %0d", exp_c.red, rsp_red);
               if (rsp_green !== exp_c.green)
                  $error("green: expected %0d, got %0d", exp_c.green, rsp_green);
               if (rsp_blue !== exp_c.blue)
                  $error("blue: expected %0d, got %0d", exp_c.blue, rsp_blue);
               if (rsp_clamped !== exp_c.clamped)
                  $error("clamped: expected %0d, got %0d", exp_c.clamped, rsp_clamped);
            end
         end
         pending <= color_q.size();
      end
   end
endmodule

FILE: verif/tb_piecewise_linear_colormap.sv
// Testbench top for the piecewise linear colormap: stimulus, registers and verdict.
`timescale 1ns / 1ps
module tb_piecewise_linear_colormap;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 30;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [pwlc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pwlc_pkg::CSR_DATA_W-1:0]  csr_write_data;
   logic                             req_valid;
   logic                             req_ready;
   logic signed [13:0]               req_pixel_index;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [7:0]                       rsp_red, rsp_green, rsp_blue;
   logic                             rsp_clamped;
   int                               fail_count;
   int                               pending;
   int                               idle_cycles;
   int                               rsp_gap;
   bit                               stim_done;

   piecewise_linear_colormap u_dut (.*);

   pwlc_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // half the time no gap, otherwise mostly short ones, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic csr_write(logic [pwlc_pkg::CSR_INDEX_W-1:0] idx,
                            logic [pwlc_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [pwlc_pkg::CSR_DATA_W-1:0] point(int pos, logic [23:0] color);
      return {12'(pos), color};
   endfunction

   task automatic send_pixel(logic signed [13:0] pix);
      req_valid       <= 1'b1;
      req_pixel_index <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_pixel(int size);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) send_pixel(14'($urandom_range(0, (size > 0) ? size - 1 : 0)));
      else send_pixel(14'($urandom));
      if (gap_len() > 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   // wait for the clock first so the checker's count covers the last transfer
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_points(int size);
      int pos;
      for (int k = 0; k < 6; k++) begin
         // ascending mostly, sometimes repeated or wild
         pos = (k * size) / 5 + $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 4095);
         csr_write(pwlc_pkg::CSR_POINT_BASE + 4'(k), point(pos, 24'($urandom)));
      end
   endtask

   // receiver stalls: single cycles and runs of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= gap_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int sizes [6];
      int sz;
      sizes = '{2, 256, 4096, 37, 8191, 0};
      stim_done        = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_pixel_index  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: black to white over 0..255
      send_pixel(14'sd0);
      send_pixel(14'sd1);
      send_pixel(14'sd128);
      send_pixel(14'sd254);
      send_pixel(14'sd255);
      send_pixel(14'sd256);
      send_pixel(-14'sd1);
      send_pixel(14'h1FFF);
      send_pixel(14'h2000);
      settle();

      // equal and descending points, point past table end, interior gap
      csr_write(pwlc_pkg::CSR_TABLE_SIZE, 36'd100);
      csr_write(pwlc_pkg::CSR_POINT_COUNT, 36'd6);
      csr_write(pwlc_pkg::CSR_POINT_BASE + 4'd0, point(10, 24'hFF0000));
      csr_write(pwlc_pkg::CSR_POINT_BASE + 4'd1, point(10, 24'h00FF00));
      csr_write(pwlc_pkg::CSR_POINT_BASE + 4'd2, point(50, 24'h0000FF));
      csr_write(pwlc_pkg::CSR_POINT_BASE + 4'd3, point(20, 24'hFFFFFF));
      csr_write(pwlc_pkg::CSR_POINT_BASE + 4'd4, point(4000, 24'h123456));
      csr_write(pwlc_pkg::CSR_POINT_BASE + 4'd5, point(4095, 24'hABCDEF));
      csr_write(4'd9, 36'hFFFFFFFFF);
      send_pixel(14'sd0);
      send_pixel(14'sd9);
      send_pixel(14'sd10);
      send_pixel(14'sd30);
      send_pixel(14'sd98);
      send_pixel(14'sd99);
      send_pixel(14'sd100);
      settle();

      // zero point count gives black; count 1 gives color at its own spot
      csr_write(pwlc_pkg::CSR_POINT_COUNT, 36'd0);
      send_pixel(14'sd10);
      settle();
      csr_write(pwlc_pkg::CSR_POINT_COUNT, 36'd1);
      send_pixel(14'sd10);
      send_pixel(14'sd11);
      settle();
      csr_write(pwlc_pkg::CSR_POINT_COUNT, 36'd7);
      csr_write(pwlc_pkg::CSR_TABLE_SIZE, 36'd0);
      send_pixel(14'sd0);
      send_pixel(14'sd5);
      settle();

      for (int ph = 0; ph < 12; ph++) begin
         sz = (ph < 6) ? sizes[ph] : $urandom_range(2, 600);
         csr_write(pwlc_pkg::CSR_TABLE_SIZE, 36'(sz));
         csr_write(pwlc_pkg::CSR_POINT_COUNT, 36'($urandom_range(0, 7)));
         if (ph % 4 == 1) csr_write(pwlc_pkg::CSR_POINT_COUNT, 36'(6));
         random_points((sz == 0) ? 1 : (sz > 4096 ? 4096 : sz));
         for (int n = 0; n < 118; n++)
            send_random_pixel((sz == 0) ? 1 : (sz > 4096 ? 4096 : sz));
         settle();
      end
      stim_done = 1'b1;

      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
